@@ hdl/rfr_pkg.sv @@
// Package for the reply frame receiver: phase and outcome codes, frame
// constants, result and configuration structs, and the CRC-32 byte step.
// Depends on nothing; every other file of the block but rfr_link_if uses it.
package rfr_pkg;

  localparam int unsigned HUNT_LIMIT = 128;
  localparam int unsigned HUNT_W     = 8;

  localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;

  localparam logic [15:0] MAGIC [4] = '{16'h0204, 16'h1017, 16'h0119, 16'h0117};

  localparam logic [15:0] REPLY_MAX_RST = 16'd4096;
  localparam logic [15:0] CRC_ERR_RST   = 16'hffff;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_STAT = 3'd2,
    PH_DATA = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_NO_REPLY = 2'd1,
    OUT_BAD_LEN  = 2'd2,
    OUT_BAD_CRC  = 2'd3
  } outcome_t;

  typedef enum logic {
    CFG_REPLY_MAX    = 1'b0,
    CFG_CRC_ERR_CODE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] reply_max;
    logic [15:0] crc_err_code;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] data_word;
    outcome_t    outcome;
    logic [15:0] remote_status;
    logic [15:0] reply_length;
    logic        last;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/rfr_link_if.sv @@
// Link word channel of the reply frame receiver.
// Carries valid, ready and one 16-bit link word; no dependencies.
interface rfr_link_if;
  logic        valid;
  logic        ready;
  logic [15:0] link_word;

  modport source (output valid, output link_word, input ready);
  modport sink (input valid, input link_word, output ready);
endinterface

@@ hdl/rfr_result_if.sv @@
// Result channel of the reply frame receiver: data words and frame results.
// Uses rfr_pkg for the outcome code type.
interface rfr_result_if;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [15:0]      data_word;
  rfr_pkg::outcome_t outcome;
  logic [15:0]      remote_status;
  logic [15:0]      reply_length;
  logic             last;

  modport source (output valid, output kind, output data_word, output outcome,
                  output remote_status, output reply_length, output last,
                  input ready);
  modport sink (input valid, input kind, input data_word, input outcome,
                input remote_status, input reply_length, input last,
                output ready);
endinterface

@@ hdl/rfr_crc_step.sv @@
// CRC-32 update over one or two bytes of a link word, high byte first.
// Uses rfr_pkg::crc_byte.
module rfr_crc_step (
  input  logic [31:0] crc_in,
  input  logic [15:0] word,
  input  logic        two_bytes,
  output logic [31:0] crc_out
);

  logic [31:0] crc_hi;

  always_comb begin
    crc_hi  = rfr_pkg::crc_byte(crc_in, word[15:8]);
    crc_out = two_bytes ? rfr_pkg::crc_byte(crc_hi, word[7:0]) : crc_hi;
  end

endmodule

@@ hdl/rfr_frame_fsm.sv @@
// Frame parser: magic hunt, header, data and CRC phases, and result build.
// Uses rfr_pkg and rfr_crc_step.
module rfr_frame_fsm (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [15:0]     word,
  input  rfr_pkg::cfg_t   cfg,
  output logic            res_valid,
  output rfr_pkg::res_t   res,
  output rfr_pkg::phase_t phase
);

  rfr_pkg::phase_t          phase_next;
  logic [1:0]               magic_matched, magic_matched_next;
  logic [rfr_pkg::HUNT_W-1:0] hunt_words, hunt_words_next;
  logic [15:0]              frame_length, frame_length_next;
  logic [15:0]              frame_status, frame_status_next;
  logic [15:0]              bytes_left, bytes_left_next;
  logic [31:0]              running_crc, running_crc_next;
  logic [15:0]              crc_high_word, crc_high_word_next;

  logic [31:0] crc_in, crc_out;
  logic        two_bytes;
  logic [16:0] rounded;
  logic [16:0] seen;
  logic [15:0] timeout_len;
  logic [15:0] clip_len;
  logic        timed_out;

  rfr_crc_step u_crc (
    .crc_in    (crc_in),
    .word      (word),
    .two_bytes (two_bytes),
    .crc_out   (crc_out)
  );

  always_comb begin
    crc_in    = (phase == rfr_pkg::PH_LEN) ? 32'h0 : running_crc;
    two_bytes = !((phase == rfr_pkg::PH_DATA) && (bytes_left < 16'd2));
    rounded   = ({1'b0, frame_length} + 17'd1) & ~17'd1;
    seen      = 17'(2 * rfr_pkg::HUNT_LIMIT);
    timeout_len = (seen < {1'b0, cfg.reply_max}) ? seen[15:0] : cfg.reply_max;
    clip_len  = (frame_length < cfg.reply_max) ? frame_length : cfg.reply_max;
    timed_out = (hunt_words + 1'b1) >= rfr_pkg::HUNT_W'(rfr_pkg::HUNT_LIMIT);
  end

  always_comb begin
    phase_next         = phase;
    magic_matched_next = magic_matched;
    hunt_words_next    = hunt_words;
    frame_length_next  = frame_length;
    frame_status_next  = frame_status;
    bytes_left_next    = bytes_left;
    running_crc_next   = running_crc;
    crc_high_word_next = crc_high_word;
    unique case (phase)
      rfr_pkg::PH_STAT: begin
        frame_status_next = word;
        running_crc_next  = crc_out;
        hunt_words_next   = '0;
        if (rounded > {1'b0, cfg.reply_max}) begin
          phase_next         = rfr_pkg::PH_HUNT;
          magic_matched_next = '0;
        end else begin
          bytes_left_next = frame_length;
          phase_next = (frame_length == 16'd0) ? rfr_pkg::PH_CRCH : rfr_pkg::PH_DATA;
        end
      end
      rfr_pkg::PH_DATA: begin
        running_crc_next = crc_out;
        bytes_left_next  = two_bytes ? bytes_left - 16'd2 : 16'd0;
        if (bytes_left_next == 16'd0) begin
          phase_next = rfr_pkg::PH_CRCH;
        end
      end
      rfr_pkg::PH_CRCH: begin
        crc_high_word_next = word;
        phase_next         = rfr_pkg::PH_CRCL;
      end
      rfr_pkg::PH_CRCL: begin
        phase_next         = rfr_pkg::PH_HUNT;
        magic_matched_next = '0;
        hunt_words_next    = '0;
      end
      rfr_pkg::PH_LEN: begin
        frame_length_next = word;
        running_crc_next  = crc_out;
        phase_next        = rfr_pkg::PH_STAT;
        hunt_words_next   = hunt_words + 1'b1;
        if (timed_out) begin
          phase_next         = rfr_pkg::PH_HUNT;
          magic_matched_next = '0;
          hunt_words_next    = '0;
        end
      end
      default: begin
        phase_next = rfr_pkg::PH_HUNT;
        if (word == rfr_pkg::MAGIC[magic_matched]) begin
          magic_matched_next = magic_matched + 2'd1;
          if (magic_matched == 2'd3) begin
            phase_next = rfr_pkg::PH_LEN;
          end
        end else begin
          magic_matched_next = '0;
        end
        hunt_words_next = hunt_words + 1'b1;
        if (timed_out) begin
          phase_next         = rfr_pkg::PH_HUNT;
          magic_matched_next = '0;
          hunt_words_next    = '0;
        end
      end
    endcase
  end

  always_comb begin
    res_valid         = 1'b0;
    res               = '0;
    res.outcome       = rfr_pkg::OUT_OK;
    unique case (phase)
      rfr_pkg::PH_STAT: begin
        if (rounded > {1'b0, cfg.reply_max}) begin
          res_valid         = 1'b1;
          res.kind          = 1'b1;
          res.outcome       = rfr_pkg::OUT_BAD_LEN;
          res.remote_status = word;
          res.reply_length  = clip_len;
          res.last          = 1'b1;
        end
      end
      rfr_pkg::PH_DATA: begin
        res_valid     = 1'b1;
        res.data_word = word;
      end
      rfr_pkg::PH_CRCH: begin
        res_valid = 1'b0;
      end
      rfr_pkg::PH_CRCL: begin
        res_valid         = 1'b1;
        res.kind          = 1'b1;
        res.outcome       = ((frame_status == cfg.crc_err_code) ||
                             ({crc_high_word, word} == running_crc)) ?
                            rfr_pkg::OUT_OK : rfr_pkg::OUT_BAD_CRC;
        res.remote_status = frame_status;
        res.reply_length  = frame_length;
        res.last          = 1'b1;
      end
      default: begin
        if (timed_out) begin
          res_valid        = 1'b1;
          res.kind         = 1'b1;
          res.outcome      = rfr_pkg::OUT_NO_REPLY;
          res.reply_length = timeout_len;
          res.last         = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rfr_pkg::PH_HUNT;
      magic_matched <= '0;
      hunt_words    <= '0;
      frame_length  <= '0;
      frame_status  <= '0;
      bytes_left    <= '0;
      running_crc   <= '0;
      crc_high_word <= '0;
    end else if (step) begin
      phase         <= phase_next;
      magic_matched <= magic_matched_next;
      hunt_words    <= hunt_words_next;
      frame_length  <= frame_length_next;
      frame_status  <= frame_status_next;
      bytes_left    <= bytes_left_next;
      running_crc   <= running_crc_next;
      crc_high_word <= crc_high_word_next;
    end
  end

endmodule

@@ hdl/reply_frame_receiver_crc32.sv @@
// Reply frame receiver with CRC-32 check, top level.
// Uses rfr_pkg, rfr_link_if, rfr_result_if and rfr_frame_fsm.
//
// Link words enter on the link channel (valid/ready); data words and one
// final frame result per frame leave on the result channel (valid/ready).
// The final result carries the outcome: ok with the remote status, no
// reply, bad length or bad CRC. Two registers are written on the cfg port
// (index 0 reply buffer size in bytes, index 1 remote CRC error status).
//
// Each link word is taken into an input register, parsed combinationally
// and its result, if any, loaded into the output register that drives
// result valid. One word is accepted every cycle while the result side
// does not stall; the parser state update and the two-byte CRC step set
// this figure.
// When the result side stalls, a word that makes a result waits in the
// input register and the link sees ready low; words that make no result
// keep flowing. Reset empties both registers, restores the register
// defaults and restarts the magic hunt.
module reply_frame_receiver_crc32 (
  input  logic              clk,
  input  logic              rst,
  rfr_link_if.sink          link,
  rfr_result_if.source      result,
  input  logic              cfg_we,
  input  rfr_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);

  rfr_pkg::cfg_t   cfg;
  rfr_pkg::res_t   res;
  rfr_pkg::res_t   out_q;
  rfr_pkg::phase_t phase;
  logic            in_valid;
  logic [15:0]     in_word;
  logic            res_valid;
  logic            out_valid;
  logic            step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_max    <= rfr_pkg::REPLY_MAX_RST;
      cfg.crc_err_code <= rfr_pkg::CRC_ERR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfr_pkg::CFG_REPLY_MAX:    cfg.reply_max    <= cfg_data;
        rfr_pkg::CFG_CRC_ERR_CODE: cfg.crc_err_code <= cfg_data;
        default:                   cfg.reply_max    <= cfg.reply_max;
      endcase
    end
  end

  assign step       = in_valid && (!res_valid || !out_valid || result.ready);
  assign link.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (link.ready) begin
      in_valid <= link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (link.ready && link.valid) begin
      in_word <= link.link_word;
    end
  end

  rfr_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word      (in_word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .phase     (phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_q.kind;
  assign result.data_word     = out_q.data_word;
  assign result.outcome       = out_q.outcome;
  assign result.remote_status = out_q.remote_status;
  assign result.reply_length  = out_q.reply_length;
  assign result.last          = out_q.last;

  a_final_restarts_hunt: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.last |=> phase == rfr_pkg::PH_HUNT)
    else $error("frame result did not restart the hunt");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_word))
    else $error("stalled input word lost");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> out_valid && (out_q == $past(res)))
    else $error("result not loaded into output register");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |-> (res.last == res.kind))
    else $error("last and kind disagree");

endmodule
